FILE: sv/ngpc_pkg.sv
// ----------------------------------------------------------------------------
// ngpc_pkg
// Shared constants and types for the nearest group point clustering block.
// ----------------------------------------------------------------------------
package ngpc_pkg;

  localparam int MAX_GROUPS  = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = $clog2(MAX_GROUPS);
  localparam int USED_W      = $clog2(MAX_GROUPS + 1);
  localparam int COORD_W     = 32;
  localparam int TOL_W       = 31;
  localparam int DIST_W      = 2 * COORD_W + 1;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(196608);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // one group entry as it travels along the chain
  typedef struct packed {
    logic signed [COORD_W-1:0] seed_x;
    logic signed [COORD_W-1:0] seed_y;
    logic signed [COORD_W-1:0] cen_x;
    logic signed [COORD_W-1:0] cen_y;
    logic [COUNT_WIDTH-1:0]    count;
  } group_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic shift;                       // rotate the ring by one place
    logic load;                        // load new entry into the tail cell
    group_t load_data;
  } cell_ctl_t;

endpackage

FILE: sv/ngpc_cell.sv
// ----------------------------------------------------------------------------
// ngpc_cell
// One storage cell of the group ring; passes its entry on when shifted.
// ----------------------------------------------------------------------------
module ngpc_cell
  import ngpc_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      is_tail,
  input  group_t    prev_entry,
  output group_t    entry
);

  group_t entry_r;

  always_ff @(posedge clk) begin
    if (ctl.load && is_tail) begin
      entry_r <= ctl.load_data;
    end else if (ctl.shift) begin
      entry_r <= prev_entry;
    end
  end

  assign entry = entry_r;

endmodule

FILE: sv/ngpc_div.sv
// ----------------------------------------------------------------------------
// ngpc_div
// Restoring divider for the running mean, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ngpc_div
  import ngpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIST_W-1:0] num,     // signed numerator
  input  logic [COUNT_WIDTH:0]     den,     // positive divisor
  output logic                     done,
  output logic signed [COORD_W-1:0] quo
);

  localparam int NUM_W = DIST_W - 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]      q_r, q_nxt;
  logic [COUNT_WIDTH:0]  rem_r, rem_nxt;
  logic [COUNT_WIDTH:0]  den_r;
  logic                  neg_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [COUNT_WIDTH+1:0] trial;
  logic [NUM_W-1:0]      mag;

  assign mag   = num[DIST_W-1] ? NUM_W'(-num) : num[NUM_W-1:0];
  assign trial = {rem_r, q_r[NUM_W-1]};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = mag;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = (COUNT_WIDTH+1)'(trial - {1'b0, den_r});
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[COUNT_WIDTH:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
      neg_r <= num[DIST_W-1];
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? COORD_W'(-q_r[COORD_W-1:0]) : q_r[COORD_W-1:0];

endmodule

FILE: sv/nearest_group_point_clustering.sv
// ----------------------------------------------------------------------------
// nearest_group_point_clustering
// Online leader clustering with nearest running-centroid assignment.
// ----------------------------------------------------------------------------
// Usage:
//   in_ channel takes one item: in_func (add point or clear), in_point_x/y.
//   out_ channel returns exactly one result item per input item, in order.
//   cfg_we/cfg_wdata write search_tolerance; write only while the block idles.
// Sequence (from the accepting edge until the result can be taken):
//   the groups live in a ring of MAX_GROUPS cells that rotates one place per
//   cycle while scanning or writing back; an add rotates the ring fully,
//   measuring one group a cycle through a two-stage distance pipe, then
//   drains the pipe. A join then runs the x and y running means through two
//   64-step dividers side by side and rotates the ring once more to write the
//   entry back. Opening a group also rotates the ring once more to write the
//   new entry; a drop and a clear go straight to the result.
//   One item at a time: in_ready is high only in idle, which the block
//   enters at the edge that takes the result.
// Reset:
//   table empties and tolerance returns to 3.0; no clearing pass is needed.
// Stall:
//   the result waits in the output register until taken; in_ready stays low.
// ----------------------------------------------------------------------------
module nearest_group_point_clustering
  import ngpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [TOL_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_func,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          out_group_index,
  output logic                      out_opened_new,
  output logic                      out_dropped,
  output logic signed [COORD_W-1:0] out_center_x,
  output logic signed [COORD_W-1:0] out_center_y,
  output logic [COUNT_WIDTH-1:0]    out_member_total
);

  localparam int MUL_W = COORD_W + COUNT_WIDTH + 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_SCAN   = 8'b00000010,
    S_DRAIN  = 8'b00000100,
    S_PREP   = 8'b00001000,
    S_DIV    = 8'b00010000,
    S_WAIT   = 8'b00100000,
    S_WRITE  = 8'b01000000,
    S_RESULT = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [TOL_W-1:0]          tol_r;
  logic [USED_W-1:0]         used_r;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic [IDX_W:0]            step_r;      // rotation counter

  // result register
  logic                      out_valid_r;
  logic [IDX_W-1:0]          res_idx_r;
  logic                      res_open_r, res_drop_r;
  logic signed [COORD_W-1:0] res_x_r, res_y_r;
  logic [COUNT_WIDTH-1:0]    res_cnt_r;

  // entry to be written during the write rotation
  group_t                    wr_data_r;
  logic [IDX_W-1:0]          wr_idx_r;

  // ring of cells: cell 0 is the head seen by the scanner, head feeds the tail
  group_t    ring [MAX_GROUPS];
  cell_ctl_t ctl;

  genvar g;
  generate
    for (g = 0; g < MAX_GROUPS; g++) begin : g_cell
      ngpc_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .is_tail    (g == MAX_GROUPS - 1),
        .prev_entry (ring[(g + 1) % MAX_GROUPS]),
        .entry      (ring[g])
      );
    end
  endgenerate

  group_t head;
  assign head = ring[0];

  logic accept;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // ---- distance pipe, stage 1: window test and abs diffs
  logic                      p1_v_r, p1_cand_r;
  logic [IDX_W-1:0]          p1_idx_r;
  logic [COORD_W-1:0]        p1_dx_r, p1_dy_r;
  group_t                    p1_ent_r;
  logic [COORD_W:0]          sdx, sdy, cdx, cdy;
  logic                      cand;

  function automatic logic [COORD_W:0] absd(input logic signed [COORD_W-1:0] a,
                                            input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    absd = d[COORD_W] ? (COORD_W+1)'(-d) : d;
  endfunction

  assign sdx = absd(head.seed_x, px_r);
  assign sdy = absd(head.seed_y, py_r);
  assign cdx = absd(head.cen_x, px_r);
  assign cdy = absd(head.cen_y, py_r);

  // only open groups take part
  assign cand = (step_r < (IDX_W+1)'(used_r)) &&
                (sdx <= {2'b0, tol_r}) && (sdy <= {2'b0, tol_r});

  // ---- stage 2: squares
  logic                      p2_v_r, p2_cand_r;
  logic [IDX_W-1:0]          p2_idx_r;
  logic [2*COORD_W-1:0]      p2_sx_r, p2_sy_r;
  group_t                    p2_ent_r;
  logic [DIST_W-1:0]         sq_dist;
  logic                      take;

  logic                      found_r;
  logic [IDX_W-1:0]          best_r;
  logic [DIST_W-1:0]         best_d_r;
  group_t                    win_r;

  assign sq_dist = {1'b0, p2_sx_r} + {1'b0, p2_sy_r};
  // strict compare keeps the earliest group on a tie
  assign take    = p2_v_r && p2_cand_r && (!found_r || sq_dist < best_d_r);

  // ---- running means
  logic                      div_start, done_x, done_y;
  logic signed [MUL_W-1:0]   mul_x, mul_y;
  logic signed [DIST_W-1:0]  num_x_r, num_y_r;
  logic signed [COORD_W-1:0] quo_x, quo_y;
  logic [COUNT_WIDTH:0]      den;
  logic [COUNT_WIDTH-1:0]    cnt_inc;

  assign mul_x = MUL_W'($signed(win_r.cen_x)) * MUL_W'($signed({1'b0, win_r.count}))
                 + MUL_W'($signed(px_r));
  assign mul_y = MUL_W'($signed(win_r.cen_y)) * MUL_W'($signed({1'b0, win_r.count}))
                 + MUL_W'($signed(py_r));
  assign den   = {1'b0, win_r.count} + (COUNT_WIDTH+1)'(1);
  assign cnt_inc = (win_r.count == COUNT_MAX) ? win_r.count : win_r.count + 1'b1;

  ngpc_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_x_r),
    .den   (den),
    .done  (done_x),
    .quo   (quo_x)
  );

  ngpc_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_y_r),
    .den   (den),
    .done  (done_y),
    .quo   (quo_y)
  );

  always_comb begin
    state_nxt     = state_r;
    ctl.shift     = 1'b0;
    ctl.load      = 1'b0;
    ctl.load_data = wr_data_r;
    div_start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_CLEAR) state_nxt = S_RESULT;
          else state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.shift = 1'b1;
        if (step_r == (IDX_W+1)'(MAX_GROUPS - 1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!p1_v_r && !p2_v_r) begin
          if (found_r) state_nxt = S_PREP;
          else if (used_r == USED_W'(MAX_GROUPS)) state_nxt = S_RESULT;
          else state_nxt = S_WRITE;
        end
      end
      S_PREP: state_nxt = S_DIV;
      S_DIV: begin
        div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: if (done_x && done_y) state_nxt = S_WRITE;
      S_WRITE: begin
        // tail takes the new entry in place of the one leaving the head
        ctl.shift = 1'b1;
        ctl.load  = (step_r[IDX_W-1:0] == wr_idx_r);
        if (step_r == (IDX_W+1)'(MAX_GROUPS - 1)) state_nxt = S_RESULT;
      end
      S_RESULT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tol_r       <= TOL_RESET;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_nxt == S_RESULT);
      if (cfg_we) tol_r <= cfg_wdata;

      p1_v_r <= (state_r == S_SCAN);
      p2_v_r <= p1_v_r;
      if (accept) found_r <= 1'b0;
      else if (take) found_r <= 1'b1;

      if (accept && in_func == FUNC_CLEAR) begin
        used_r <= '0;
      end else if (state_r == S_DRAIN && state_nxt == S_WRITE) begin
        used_r <= used_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
    end
    if (accept || state_r == S_DRAIN) begin
      step_r <= '0;
    end else if (state_r == S_SCAN || state_r == S_WRITE) begin
      step_r <= step_r + 1'b1;
    end

    p1_idx_r  <= step_r[IDX_W-1:0];
    p1_cand_r <= cand;
    p1_dx_r   <= cdx[COORD_W-1:0];
    p1_dy_r   <= cdy[COORD_W-1:0];
    p1_ent_r  <= head;
    p2_idx_r  <= p1_idx_r;
    p2_cand_r <= p1_cand_r;
    p2_sx_r   <= (2*COORD_W)'(p1_dx_r) * (2*COORD_W)'(p1_dx_r);
    p2_sy_r   <= (2*COORD_W)'(p1_dy_r) * (2*COORD_W)'(p1_dy_r);
    p2_ent_r  <= p1_ent_r;
    if (take) begin
      best_r   <= p2_idx_r;
      best_d_r <= sq_dist;
      win_r    <= p2_ent_r;
    end

    if (state_r == S_PREP) begin
      num_x_r <= {{(DIST_W-MUL_W){mul_x[MUL_W-1]}}, mul_x};
      num_y_r <= {{(DIST_W-MUL_W){mul_y[MUL_W-1]}}, mul_y};
    end

    if (accept && in_func == FUNC_CLEAR) begin
      res_open_r <= 1'b0;
      res_drop_r <= 1'b0;
      res_idx_r  <= '0;
      res_x_r    <= '0;
      res_y_r    <= '0;
      res_cnt_r  <= '0;
    end else if (state_r == S_DRAIN && !p1_v_r && !p2_v_r && !found_r) begin
      res_open_r <= 1'b0;
      res_drop_r <= 1'b0;
      res_idx_r  <= '0;
      res_x_r    <= '0;
      res_y_r    <= '0;
      res_cnt_r  <= '0;
      if (used_r == USED_W'(MAX_GROUPS)) begin
        res_drop_r <= 1'b1;
      end else begin
        res_open_r <= 1'b1;
        res_idx_r  <= used_r[IDX_W-1:0];
        res_x_r    <= px_r;
        res_y_r    <= py_r;
        res_cnt_r  <= COUNT_WIDTH'(1);
        wr_idx_r   <= used_r[IDX_W-1:0];
        wr_data_r  <= '{seed_x: px_r, seed_y: py_r, cen_x: px_r, cen_y: py_r,
                        count: COUNT_WIDTH'(1)};
      end
    end else if (state_r == S_WAIT && done_x && done_y) begin
      res_open_r <= 1'b0;
      res_drop_r <= 1'b0;
      res_idx_r  <= best_r;
      res_x_r    <= quo_x;
      res_y_r    <= quo_y;
      res_cnt_r  <= cnt_inc;
      wr_idx_r   <= best_r;
      wr_data_r  <= '{seed_x: win_r.seed_x, seed_y: win_r.seed_y, cen_x: quo_x,
                      cen_y: quo_y, count: cnt_inc};
    end
  end

  assign out_valid        = out_valid_r;
  assign out_group_index  = res_idx_r;
  assign out_opened_new   = res_open_r;
  assign out_dropped      = res_drop_r;
  assign out_center_x     = res_x_r;
  assign out_center_y     = res_y_r;
  assign out_member_total = res_cnt_r;

endmodule
